// ===== rtl/tpdc_pkg.sv =====
// shared types and constants for the token prefix digest chain
// no dependencies
`default_nettype none

package tpdc_pkg;

  localparam logic [63:0] DIGEST_OFFSET  = 64'hcbf29ce484222325;
  localparam logic [63:0] DIGEST_PRIME   = 64'd1099511628211;
  localparam logic [63:0] TOKEN_DOMAIN   = 64'h6e696e6665722d74;
  localparam logic [63:0] REWRITE_DOMAIN = 64'h6e696e6665722d72;

  localparam logic [1:0] MODE_CONTINUE = 2'd0;
  localparam logic [1:0] MODE_RESTART  = 2'd1;
  localparam logic [1:0] MODE_RESUME   = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        resume_digest;
    logic [31:0]        resume_length;
    logic [31:0]        token_id;
    logic [7:0]         tok_kind;
    logic signed [31:0] pos_axis0;
    logic signed [31:0] pos_axis1;
    logic signed [31:0] pos_axis2;
    logic               rewrite_mark;
  } in_item_t;

  typedef struct packed {
    logic [63:0] prefix_digest;
    logic [31:0] prefix_length;
  } out_item_t;

  // one byte of the serial stream
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } byte_beat_t;

endpackage

`default_nettype wire

// ===== rtl/tpdc_ser.sv =====
// byte serializer: holds one item's fields and streams its words lsb byte first
// depends on tpdc_pkg
`default_nettype none

module tpdc_ser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire tpdc_pkg::in_item_t   item,
  input  wire logic [31:0]          new_length,
  output tpdc_pkg::byte_beat_t      beat
);
  import tpdc_pkg::*;

  logic        active_r, active_nxt;
  logic [2:0]  word_r, word_nxt;
  logic [2:0]  byte_r, byte_nxt;
  logic [63:0] sr_r, sr_nxt;
  logic [31:0] id_r, ax0_r, ax1_r, ax2_r, len_r;
  logic [7:0]  type_r;
  logic        mark_r;
  logic [2:0]  last_word;
  logic        last_beat;

  function automatic logic [63:0] word_at(input logic [2:0] idx);
    logic [63:0] w;
    case (idx)
      3'd0:    w = TOKEN_DOMAIN;
      3'd1:    w = {32'd0, id_r};
      3'd2:    w = {56'd0, type_r};
      3'd3:    w = {32'd0, ax0_r};
      3'd4:    w = {32'd0, ax1_r};
      3'd5:    w = {32'd0, ax2_r};
      3'd6:    w = REWRITE_DOMAIN;
      3'd7:    w = {32'd0, len_r};
      default: w = '0;
    endcase
    return w;
  endfunction

  assign last_word = mark_r ? 3'd7 : 3'd5;
  assign last_beat = active_r && (byte_r == 3'd7) && (word_r == last_word);

  assign beat.valid = active_r;
  assign beat.last  = last_beat;
  assign beat.data  = sr_r[7:0];

  always_comb begin
    active_nxt = active_r;
    word_nxt   = word_r;
    byte_nxt   = byte_r;
    sr_nxt     = sr_r;
    if (start) begin
      active_nxt = 1'b1;
      word_nxt   = 3'd0;
      byte_nxt   = 3'd0;
      sr_nxt     = TOKEN_DOMAIN;
    end else if (active_r) begin
      byte_nxt = byte_r + 3'd1;
      if (byte_r == 3'd7) begin
        if (last_beat) begin
          active_nxt = 1'b0;
        end
        word_nxt = word_r + 3'd1;
        sr_nxt   = word_at(word_r + 3'd1);
      end else begin
        sr_nxt = {8'd0, sr_r[63:8]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      word_r   <= 3'd0;
      byte_r   <= 3'd0;
    end else begin
      active_r <= active_nxt;
      word_r   <= word_nxt;
      byte_r   <= byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
    if (start) begin
      id_r   <= item.token_id;
      type_r <= item.tok_kind;
      ax0_r  <= $unsigned(item.pos_axis0);
      ax1_r  <= $unsigned(item.pos_axis1);
      ax2_r  <= $unsigned(item.pos_axis2);
      mark_r <= item.rewrite_mark;
      len_r  <= new_length;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tpdc_mix.sv =====
// digest register with one xor-multiply round per byte
// depends on tpdc_pkg
`default_nettype none

module tpdc_mix (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire logic [63:0]          load_val,
  input  wire tpdc_pkg::byte_beat_t beat,
  output logic [63:0]               digest
);
  import tpdc_pkg::*;

  logic [63:0] digest_r, digest_nxt;
  logic [63:0] mixed;
  logic [63:0] prod;

  // multiply by the prime 2^40 + 0x1b3 as a sum of shifts, mod 2^64
  function automatic logic [63:0] mul_prime(input logic [63:0] h);
    return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

  assign mixed = digest_r ^ {56'd0, beat.data};
  assign prod  = mul_prime(mixed);

  always_comb begin
    digest_nxt = digest_r;
    if (load) begin
      digest_nxt = load_val;
    end else if (beat.valid) begin
      digest_nxt = prod;
      // an emitted digest is never zero
      if (beat.last && (prod == 64'd0)) begin
        digest_nxt = 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digest_r <= DIGEST_OFFSET;
    end else begin
      digest_r <= digest_nxt;
    end
  end

  assign digest = digest_r;

endmodule

`default_nettype wire

// ===== rtl/token_prefix_digest_chain_core.sv =====
// running fnv-1a 64-bit digest over a token prefix, one byte per cycle
// a new item is taken only when idle, after the prior result is registered
// each item's bytes go through the single xor-multiply round, one per cycle;
// rewrite_mark adds the rewrite domain and length words to the stream
// reset: synchronous active-low rst_n; digest returns to the offset basis,
// prefix length to zero, no result pending
// depends on tpdc_pkg, tpdc_ser, tpdc_mix
`default_nettype none

module token_prefix_digest_chain_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tpdc_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tpdc_pkg::out_item_t       out_data
);
  import tpdc_pkg::*;

  // one-hot control states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] base_len;
  logic [63:0] start_digest;
  logic [63:0] digest;
  logic        in_acc;
  logic        out_load;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;
  byte_beat_t  beat;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // chain start for this item: continue, restart or resume
  always_comb begin
    case (in_data.mode)
      MODE_RESTART: begin
        base_len     = 32'd0;
        start_digest = DIGEST_OFFSET;
      end
      MODE_RESUME: begin
        base_len     = in_data.resume_length;
        start_digest = in_data.resume_digest;
      end
      default: begin
        // continue, also taken for the unused mode code
        base_len     = count_r;
        start_digest = digest;
      end
    endcase
  end

  // length is bumped before the rewrite words are streamed, wraps at 32 bits
  assign count_nxt = in_acc ? (base_len + 32'd1) : count_r;

  tpdc_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc),
    .item       (in_data),
    .new_length (count_nxt),
    .beat       (beat)
  );

  tpdc_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_acc),
    .load_val (start_digest),
    .beat     (beat),
    .digest   (digest)
  );

  // done waits here until the output register is free
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (beat.valid && beat.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.prefix_digest <= digest;
      out_data_r.prefix_length <= count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an accepted item always starts the byte stream
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_RUN && beat.valid))
    else $error("accepted item did not start streaming");

  // bytes only flow while running
  a_beat_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    beat.valid |-> (state_r == S_RUN))
    else $error("byte stream active outside run state");

  // a fresh result never carries a zero digest
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_data_r.prefix_digest != 64'd0))
    else $error("zero digest emitted");

endmodule

`default_nettype wire

// ===== tb/tpdc_digest_checker.sv =====
`timescale 1ns / 1ps
// prefix digest checker: watches both channels of the digest chain core,
// predicts each fnv-1a prefix digest and compares it with the emitted one
// depends on tpdc_pkg for the item types and the hash constants
module tpdc_digest_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  tpdc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  tpdc_pkg::out_item_t out_data,
  output int unsigned         digests_pending,
  output int unsigned         digests_checked,
  output int unsigned         mismatch_count
);
  import tpdc_pkg::*;

  // small ring of predicted results, far deeper than the core can hold
  localparam int unsigned EXP_DEPTH = 16;

  logic [63:0] chain_digest;
  logic [31:0] chain_length;
  out_item_t   expected_digests [EXP_DEPTH];
  int unsigned exp_wr;
  int unsigned exp_rd;
  out_item_t   oldest;

  // eight bytes, low byte first, each through xor then multiply
  function automatic logic [63:0] fold_word64(input logic [63:0] h, input logic [63:0] w);
    for (int b = 0; b < 8; b++) begin
      h = (h ^ {56'd0, w[8*b +: 8]}) * DIGEST_PRIME;
    end
    return h;
  endfunction

  // advances the predicted chain by one token and returns the item it emits
  function automatic out_item_t advance_chain(input in_item_t tok);
    logic [63:0] h;
    out_item_t   res;
    case (tok.mode)
      MODE_RESTART: begin
        chain_digest = DIGEST_OFFSET;
        chain_length = '0;
      end
      MODE_RESUME: begin
        chain_digest = tok.resume_digest;
        chain_length = tok.resume_length;
      end
      default: ;
    endcase
    h = fold_word64(chain_digest, TOKEN_DOMAIN);
    h = fold_word64(h, {32'd0, tok.token_id});
    h = fold_word64(h, {56'd0, tok.tok_kind});
    h = fold_word64(h, {32'd0, tok.pos_axis0});
    h = fold_word64(h, {32'd0, tok.pos_axis1});
    h = fold_word64(h, {32'd0, tok.pos_axis2});
    chain_length = chain_length + 32'd1;
    if (tok.rewrite_mark) begin
      h = fold_word64(h, REWRITE_DOMAIN);
      h = fold_word64(h, {32'd0, chain_length});
    end
    if (h == 64'd0) h = 64'd1;
    chain_digest      = h;
    res.prefix_digest = h;
    res.prefix_length = chain_length;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      chain_digest = DIGEST_OFFSET;
      chain_length = '0;
      exp_wr       = 0;
      exp_rd       = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_digests[exp_wr[3:0]] = advance_chain(in_data);
        exp_wr++;
      end
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          $error("unexpected result: prefix_digest %h prefix_length %0d",
                 out_data.prefix_digest, out_data.prefix_length);
          mismatch_count++;
        end else begin
          oldest = expected_digests[exp_rd[3:0]];
          exp_rd++;
          digests_checked++;
          if (out_data.prefix_digest !== oldest.prefix_digest) begin
            $error("prefix_digest mismatch: expected %h, actual %h",
                   oldest.prefix_digest, out_data.prefix_digest);
            mismatch_count++;
          end
          if (out_data.prefix_length !== oldest.prefix_length) begin
            $error("prefix_length mismatch: expected %0d, actual %0d",
                   oldest.prefix_length, out_data.prefix_length);
            mismatch_count++;
          end
        end
      end
    end
    digests_pending = exp_wr - exp_rd;
  end

endmodule

// ===== tb/token_prefix_digest_chain_core_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the token prefix digest chain core: drives tokens and the
// result channel's ready, and gives the verdict from the digest checker
// depends on tpdc_pkg, token_prefix_digest_chain_core and tpdc_digest_checker
module token_prefix_digest_chain_core_tb;
  import tpdc_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RANDOM_ITEMS = 1600;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          IDLE_PERCENT = 18;
  // the mode code the package leaves unnamed; the core must treat it as continue
  localparam logic [1:0]  MODE_SPARE   = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int unsigned digests_pending;
  int unsigned digests_checked;
  int unsigned mismatch_count;

  // shared between the token driver and the ready driver
  bit calm         = 1'b0;  // no idling on either side while set
  bit hold_request = 1'b0;  // asks the ready driver for one long hold-off

  int unsigned tokens_sent, restarts, resumes, spares, rewrites;
  int unsigned cycle_count = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  token_prefix_digest_chain_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tpdc_digest_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .digests_pending (digests_pending),
    .digests_checked (digests_checked),
    .mismatch_count  (mismatch_count)
  );

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d digests still pending",
             cycle_count, digests_pending);
    $display("simulation failed");
    $finish;
  end

  // result side ready: random idling, none in the calm stretch, and one long
  // hold-off counted here so the core fills up and backs up its input
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ready   <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // half ordinary values, half the edges of a 32-bit word
  function automatic logic [31:0] pick_word32();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_token(input logic [1:0] mode, input logic [63:0] rdig,
                                          input logic [31:0] rlen, input logic [31:0] id,
                                          input logic [7:0] ttype, input logic [31:0] a0,
                                          input logic [31:0] a1, input logic [31:0] a2,
                                          input logic mark);
    in_item_t tok;
    tok.mode          = mode;
    tok.resume_digest = rdig;
    tok.resume_length = rlen;
    tok.token_id      = id;
    tok.tok_kind      = ttype;
    tok.pos_axis0     = a0;
    tok.pos_axis1     = a1;
    tok.pos_axis2     = a2;
    tok.rewrite_mark  = mark;
    return tok;
  endfunction

  // long continue chains with random content, occasional restarts and resumes;
  // resume lengths lean toward the wrap point
  function automatic in_item_t random_token();
    int          r;
    logic [1:0]  mode;
    logic [31:0] rlen;
    logic [7:0]  ttype;
    r = $urandom_range(99);
    if (r < 84)      mode = MODE_CONTINUE;
    else if (r < 90) mode = MODE_RESTART;
    else if (r < 96) mode = MODE_RESUME;
    else             mode = MODE_SPARE;
    case ($urandom_range(3))
      0:       rlen = 32'hffff_ffff - $urandom_range(3);
      default: rlen = $urandom;
    endcase
    case ($urandom_range(5))
      0:       ttype = 8'h00;
      1:       ttype = 8'hff;
      default: ttype = 8'($urandom_range(255));
    endcase
    return make_token(mode, {$urandom, $urandom}, rlen, pick_word32(), ttype,
                      pick_word32(), pick_word32(), pick_word32(),
                      ($urandom_range(3) == 0));
  endfunction

  // random idle cycles first, then valid held until the core takes the item
  task automatic offer_token(input in_item_t tok);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= tok;
    do @(posedge clk); while (!in_ready);
    tokens_sent++;
    if (tok.mode == MODE_RESTART) restarts++;
    if (tok.mode == MODE_RESUME)  resumes++;
    if (tok.mode == MODE_SPARE)   spares++;
    if (tok.rewrite_mark)         rewrites++;
  endtask

  // sender pause until every predicted digest has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (digests_pending != 0) @(negedge clk);
  endtask

  initial begin
    tokens_sent = 0;
    restarts    = 0;
    resumes     = 0;
    spares      = 0;
    rewrites    = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: first token off the offset basis, field extremes
    offer_token(make_token(MODE_CONTINUE, '0, '0, '0, 8'h00, '0, '0, '0, 1'b0));
    offer_token(make_token(MODE_CONTINUE, '0, '0, 32'hffff_ffff, 8'hff,
                           32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1));
    offer_token(make_token(MODE_RESTART, '0, '0, 32'd1, 8'h00, '0, '0, '0, 1'b0));
    // resume from a zero digest, taken as given
    offer_token(make_token(MODE_RESUME, 64'd0, 32'd0, '0, 8'h00, '0, '0, '0, 1'b0));
    // resume at the top length: count wraps to zero and the mark folds that zero
    offer_token(make_token(MODE_RESUME, '1, 32'hffff_ffff, 32'h8000_0000, 8'h80,
                           32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 1'b1));
    offer_token(make_token(MODE_CONTINUE, '1, '1, 32'h1234_5678, 8'h01,
                           32'h7fff_ffff, 32'h8000_0000, 32'hffff_fffe, 1'b1));
    // spare mode with resume fields full: must continue the chain
    offer_token(make_token(MODE_SPARE, '1, '1, 32'hdead_beef, 8'h7f, 32'd5, 32'd6, 32'd7,
                           1'b0));
    // restart ignores the resume fields too
    offer_token(make_token(MODE_RESTART, '1, '1, 32'h0000_0000, 8'hff, '0, '0, '0, 1'b1));
    offer_token(make_token(MODE_CONTINUE, '0, '0, 32'h7fff_ffff, 8'h00, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 1'b0));
    // length one short of the wrap, then wrap on a plain continue
    offer_token(make_token(MODE_RESUME, 64'h0123_4567_89ab_cdef, 32'hffff_fffe, 32'd42,
                           8'h10, 32'hffff_ff00, 32'd0, 32'd100, 1'b0));
    offer_token(make_token(MODE_CONTINUE, '0, '0, 32'd43, 8'h10, 32'hffff_ff01, 32'd0,
                           32'd101, 1'b1));
    offer_token(make_token(MODE_CONTINUE, '0, '0, 32'd44, 8'h10, 32'hffff_ff02, 32'd0,
                           32'd102, 1'b0));
    offer_token(make_token(MODE_RESUME, {$urandom, $urandom}, $urandom, $urandom, 8'h55,
                           $urandom, $urandom, $urandom, 1'b1));
    offer_token(make_token(MODE_SPARE, '0, '0, 32'hffff_ffff, 8'haa, '1, '0, '1, 1'b1));
    offer_token(make_token(MODE_RESTART, '0, '0, 32'haaaa_aaaa, 8'h55, 32'h5555_5555,
                           32'haaaa_aaaa, 32'h5555_5555, 1'b0));
    wait_drained();

    // long receiver hold-off while tokens keep coming: the core must stall its input
    hold_request = 1'b1;
    repeat (10) offer_token(random_token());
    wait_drained();

    // random chains, with one stretch of no idling and one mid-run pause
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 500 && i < 800);
      if (i == 1100) wait_drained();
      offer_token(random_token());
    end
    calm = 1'b0;

    // drain, then a little over the rewrite latency to catch any stray result
    wait_drained();
    repeat (80) @(negedge clk);

    $display("sent %0d tokens: %0d restarts, %0d resumes, %0d spare mode, %0d rewrite marks",
             tokens_sent, restarts, resumes, spares, rewrites);
    $display("checked %0d prefix digests, including a %0d-cycle result hold-off",
             digests_checked, HOLD_CYCLES);
    if (mismatch_count == 0 && digests_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tpdc_pkg.sv
rtl/tpdc_ser.sv
rtl/tpdc_mix.sv
rtl/token_prefix_digest_chain_core.sv
tb/tpdc_digest_checker.sv
tb/token_prefix_digest_chain_core_tb.sv
